[rtl/ovns_pkg.sv]
// Shared types and constants for the octave value-noise sampler.
package ovns_pkg;

	localparam int COORD_W = 6;
	localparam int VALUE_W = 16;
	localparam int NOISE_W = 17;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic               action;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [NOISE_W-1:0] noise;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} rsp_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pix_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_RUN,
		CORE_DRAIN,
		CORE_HAND
	} core_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_DONE
	} div_state_t;

	typedef enum logic [1:0] {
		CORNER_A,
		CORNER_B,
		CORNER_C
	} corner_t;

endpackage

[rtl/ovns_core.sv]
// Lattice memory, octave sequencer and multiply-accumulate of the noise sum.
module ovns_core #(
	parameter int LOG_SIZE = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  ovns_pkg::req_t       req,
	output logic                 sum_valid,
	input  logic                 sum_ready,
	output logic [LOG_SIZE+17:0] sum,
	output ovns_pkg::pix_t       pix
);
	import ovns_pkg::*;

	localparam int AW    = 2 * LOG_SIZE;
	localparam int OCT_W = $clog2(LOG_SIZE + 1);
	localparam int F_W   = LOG_SIZE + 1;
	localparam int WGT_W = LOG_SIZE + 2;
	localparam int SUM_W = LOG_SIZE + 18;
	localparam logic [OCT_W-1:0] OCT_MAX = OCT_W'(LOG_SIZE);

	logic [VALUE_W-1:0] mem [1 << AW];
	logic [VALUE_W-1:0] rd_q;

	core_state_t state_q, state_d;
	logic [LOG_SIZE-1:0] x_q, y_q;
	pix_t                pix_q;
	logic [OCT_W-1:0]    oct_q;
	corner_t             sel_q;
	logic                v_s1, v_s2;
	logic [WGT_W-1:0]    w_s1;
	logic [SUM_W-1:0]    prod_s2;
	logic [SUM_W-1:0]    acc_q;

	logic                issue, start, mem_we, last_issue;
	logic [AW-1:0]       mem_addr, wr_addr, rd_addr;
	logic [F_W-1:0]      f;
	logic [LOG_SIZE-1:0] low, px, py, cx, cy, nx, ny;
	logic [WGT_W-1:0]    wgt;

	assign start   = req_valid && req_ready && (req.action == ACT_QUERY);
	assign mem_we  = req_valid && req_ready && (req.action == ACT_WRITE);
	assign wr_addr = {LOG_SIZE'(req.y), LOG_SIZE'(req.x)};
	assign mem_addr = mem_we ? wr_addr : rd_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= req.value;
		end
		rd_q <= mem[mem_addr];
	end

	assign f   = F_W'(1) << oct_q;
	assign low = LOG_SIZE'(f - F_W'(1));
	assign px  = x_q & low;
	assign py  = y_q & low;
	assign cx  = x_q & ~low;
	assign cy  = y_q & ~low;
	assign nx  = cx + LOG_SIZE'(f);
	assign ny  = cy + LOG_SIZE'(f);
	assign last_issue = (oct_q == '0) && (sel_q == CORNER_C);

	always_comb begin
		case (sel_q)
			CORNER_A: begin
				rd_addr = {cy, cx};
				wgt     = {f, 1'b0} - WGT_W'(px) - WGT_W'(py);
			end
			CORNER_B: begin
				rd_addr = {cy, nx};
				wgt     = WGT_W'(px);
			end
			CORNER_C: begin
				rd_addr = {ny, cx};
				wgt     = WGT_W'(py);
			end
			default: begin
				rd_addr = '0;
				wgt     = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CORE_IDLE: begin
				if (start) begin
					state_d = CORE_RUN;
				end
			end
			CORE_RUN: begin
				if (last_issue) begin
					state_d = CORE_DRAIN;
				end
			end
			CORE_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = CORE_HAND;
				end
			end
			CORE_HAND: begin
				if (sum_ready) begin
					state_d = CORE_IDLE;
				end
			end
			default: state_d = CORE_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == CORE_IDLE);
		sum_valid = (state_q == CORE_HAND);
		issue     = (state_q == CORE_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			oct_q   <= '0;
			sel_q   <= CORNER_A;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			if (start) begin
				oct_q <= OCT_MAX;
				sel_q <= CORNER_A;
			end else if (issue) begin
				case (sel_q)
					CORNER_A: sel_q <= CORNER_B;
					CORNER_B: sel_q <= CORNER_C;
					default: begin
						sel_q <= CORNER_A;
						oct_q <= oct_q - OCT_W'(1);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q           <= LOG_SIZE'(req.x);
			y_q           <= LOG_SIZE'(req.y);
			pix_q.pixel_x <= req.x;
			pix_q.pixel_y <= req.y;
			acc_q         <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
		w_s1    <= wgt;
		prod_s2 <= SUM_W'(rd_q) * SUM_W'(w_s1);
	end

	assign sum = acc_q;
	assign pix = pix_q;

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CORE_IDLE |-> !v_s1 && !v_s2)
		else $error("pipeline active while idle");

	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CORE_RUN && last_issue) |=> state_q == CORE_DRAIN)
		else $error("sequencer missed the final octave");

	a_hand_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CORE_HAND && !sum_ready) |=> state_q == CORE_HAND && $stable(acc_q))
		else $error("sum changed during handoff");

endmodule

[rtl/ovns_div.sv]
// Division of the octave sum by 2N-1 through a reciprocal multiply, with result register.
module ovns_div #(
	parameter int LOG_SIZE = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sum_valid,
	output logic                 sum_ready,
	input  logic [LOG_SIZE+17:0] sum,
	input  ovns_pkg::pix_t       pix,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output ovns_pkg::rsp_t       rsp
);
	import ovns_pkg::*;

	localparam int              SUM_W   = LOG_SIZE + 18;
	localparam int              RECIP_W = SUM_W + 1;
	localparam int              PROD_W  = SUM_W + RECIP_W;
	localparam int              SHIFT   = SUM_W + LOG_SIZE + 1;
	localparam longint unsigned DIVISOR = (64'd1 << (LOG_SIZE + 1)) - 64'd1;
	localparam longint unsigned RECIP   = ((64'd1 << SHIFT) + DIVISOR - 64'd1) / DIVISOR;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	div_state_t state_q, state_d;
	logic [PROD_W-1:0] prod_q;
	pix_t              pix_q;

	logic              load;

	assign load = sum_valid && sum_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (sum_valid) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: begin
				if (rsp_ready) begin
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		sum_ready = (state_q == DIV_IDLE);
		rsp_valid = (state_q == DIV_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PROD_W'(sum) * PROD_W'(RECIP_C);
			pix_q  <= pix;
		end
	end

	assign rsp.noise   = prod_q[SHIFT +: NOISE_W];
	assign rsp.pixel_x = pix_q.pixel_x;
	assign rsp.pixel_y = pix_q.pixel_y;

	a_noise_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DIV_DONE |-> !prod_q[PROD_W-1] && (rsp.noise != '1))
		else $error("quotient out of range");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> state_q == DIV_DONE)
		else $error("sum taken without a result");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV_DONE && !rsp_ready) |=> state_q == DIV_DONE && $stable(prod_q))
		else $error("result lost before it was taken");

endmodule

[rtl/octave_value_noise_sampler_top.sv]
// Octave value-noise sampler: lattice writes and pixel queries, one result per query.
// Writes are taken while the core is idle, at one per cycle when issued back to back.
// A query holds the core for three reads per octave from the single-port lattice
// memory, plus pipeline drain and handoff. A held result stalls the next query only at
// its handoff. Reset clears control state, not the lattice.
module octave_value_noise_sampler_top #(
	parameter int LOG_SIZE = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ovns_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ovns_pkg::rsp_t rsp
);
	import ovns_pkg::*;

	logic                 sum_valid, sum_ready;
	logic [LOG_SIZE+17:0] sum;
	pix_t                 pix;

	ovns_core #(
		.LOG_SIZE(LOG_SIZE)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum       (sum),
		.pix       (pix)
	);

	ovns_div #(
		.LOG_SIZE(LOG_SIZE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum       (sum),
		.pix       (pix),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the octave value-noise sampler: lattice loads and pixel queries.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ovns_pkg::*;

	localparam int          LOG_SIZE     = 6;
	localparam int unsigned SIDE         = 1 << LOG_SIZE;
	localparam int unsigned CELLS        = SIDE * SIDE;
	localparam int          CLK_PERIOD   = 12;
	localparam longint      LIMIT_CYCLES = 3_000_000;

	class noise_scoreboard;
		logic [VALUE_W-1:0] lattice_copy [CELLS];
		rsp_t               awaited [$];
		int unsigned        errors;
		int unsigned        results;

		function new();
			errors  = 0;
			results = 0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function logic [NOISE_W-1:0] noise_at(int unsigned x, int unsigned y);
			longint unsigned acc;
			int unsigned     f, cx, cy, nx, ny, px, py;
			longint unsigned a, b, c;
			acc = 0;
			for (f = SIDE; f >= 1; f = f >> 1) begin
				cx  = (x / f) * f;
				cy  = (y / f) * f;
				nx  = (cx + f) % SIDE;
				ny  = (cy + f) % SIDE;
				px  = x % f;
				py  = y % f;
				a   = lattice_copy[cy * SIDE + cx];
				b   = lattice_copy[cy * SIDE + nx];
				c   = lattice_copy[ny * SIDE + cx];
				acc = acc + a * (2 * f - px - py) + b * px + c * py;
			end
			return NOISE_W'(acc / (2 * SIDE - 1));
		endfunction

		function void note_request(req_t r);
			int unsigned x, y;
			rsp_t        e;
			x = r.x % SIDE;
			y = r.y % SIDE;
			if (r.action == ACT_WRITE) begin
				lattice_copy[y * SIDE + x] = r.value;
			end else begin
				e.noise   = noise_at(x, y);
				e.pixel_x = r.x;
				e.pixel_y = r.y;
				awaited.push_back(e);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t e;
			results++;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, expected none, got noise %0d at (%0d,%0d)",
					$time, got.noise, got.pixel_x, got.pixel_y);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (got.noise !== e.noise) begin
				$display("%0t: noise mismatch, expected %0d, got %0d", $time, e.noise, got.noise);
				errors++;
			end
			if (got.pixel_x !== e.pixel_x) begin
				$display("%0t: pixel_x mismatch, expected %0d, got %0d",
					$time, e.pixel_x, got.pixel_x);
				errors++;
			end
			if (got.pixel_y !== e.pixel_y) begin
				$display("%0t: pixel_y mismatch, expected %0d, got %0d",
					$time, e.pixel_y, got.pixel_y);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	noise_scoreboard sb = new();
	int unsigned     burst_left = 0;

	octave_value_noise_sampler_top #(
		.LOG_SIZE(LOG_SIZE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		rsp_ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("tb_top: done, errors");
		$finish;
	end

	// hold valid through a burst, gap between bursts
	task automatic send(input req_t r);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		burst_left--;
		sb.note_request(r);
	endtask

	task automatic idle_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		burst_left = 0;
	endtask

	task automatic load_lattice();
		req_t r;
		for (int unsigned i = 0; i < CELLS; i++) begin
			r.action = ACT_WRITE;
			r.x      = COORD_W'(i % SIDE);
			r.y      = COORD_W'(i / SIDE);
			case ($urandom_range(0, 9))
				0:       r.value = '0;
				1:       r.value = '1;
				default: r.value = VALUE_W'($urandom);
			endcase
			send(r);
		end
	endtask

	task automatic query(input int unsigned x, input int unsigned y);
		req_t r;
		r.action = ACT_QUERY;
		r.x      = COORD_W'(x);
		r.y      = COORD_W'(y);
		r.value  = VALUE_W'($urandom);
		send(r);
	endtask

	task automatic write_word(input int unsigned x, input int unsigned y,
			input logic [VALUE_W-1:0] v);
		req_t r;
		r.action = ACT_WRITE;
		r.x      = COORD_W'(x);
		r.y      = COORD_W'(y);
		r.value  = v;
		send(r);
	endtask

	initial begin : stimulus
		req_t        r;
		int unsigned pick;
		@(posedge arst_n);
		@(posedge clk);

		load_lattice();
		// saturate every corner that the origin reads
		for (int unsigned f = SIDE; f >= 1; f = f >> 1) begin
			write_word(f % SIDE, 0, '1);
			write_word(0, f % SIDE, '1);
		end
		query(0, 0);
		query(SIDE - 1, SIDE - 1);
		query(0, SIDE - 1);
		query(SIDE - 1, 0);
		query(SIDE / 2 - 1, SIDE / 2);
		idle_until_drained();

		write_word(0, 0, '0);
		query(0, 0);
		write_word(SIDE - 1, SIDE - 1, '1);
		query(SIDE - 1, SIDE - 1);
		write_word(SIDE / 2, 0, 16'h8000);
		query(SIDE / 2, SIDE / 2);
		query(1, SIDE - 1);
		query(SIDE - 2, 1);
		query(SIDE / 2 - 1, SIDE / 2 - 1);
		write_word(0, SIDE / 2, 16'h7fff);
		query(0, SIDE / 2 + 1);

		for (int unsigned i = 0; i < 1650; i++) begin
			if (i == 800)
				idle_until_drained();
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				r.action = ACT_WRITE;
				r.value  = (pick < 2) ? '0 : (pick < 4) ? '1 : VALUE_W'($urandom);
			end else begin
				r.action = ACT_QUERY;
				r.value  = VALUE_W'($urandom);
			end
			case ($urandom_range(0, 9))
				0:       r.x = '0;
				1:       r.x = '1;
				default: r.x = COORD_W'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0:       r.y = '0;
				1:       r.y = '1;
				default: r.y = COORD_W'($urandom);
			endcase
			send(r);
		end

		idle_until_drained();
		repeat (3 * (LOG_SIZE + 1) + 40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin : result_side
		int unsigned mode, mode_left, hold_left;
		bit          held;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
			// stall long once so the block backs up into the request side
			if (!held && sb.results >= 300) begin
				held      = 1'b1;
				hold_left = 600;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else case (mode)
				0:       rsp_ready <= 1'b1;
				1:       rsp_ready <= ($urandom_range(0, 3) != 0);
				2:       rsp_ready <= 1'($urandom_range(0, 1));
				default: rsp_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

endmodule
